FILE: design/gpr_pkg.sv
package gpr_pkg;

  // Default payload size of a data packet, in bytes
  localparam int DATA_BYTES_DEF = 64;
  // Most payload results one data packet may cause
  localparam int MAX_RESULTS = 64;
  localparam int RES_W = $clog2(MAX_RESULTS + 1);

  localparam logic [6:0]  START_CODE   = 7'h10;
  localparam logic [6:0]  SIZE_CONTROL = 7'd9;
  localparam logic [6:0]  SIZE_DATA    = 7'd2;
  localparam logic [15:0] CHK_BASE     = 16'haaaa;
  localparam logic [15:0] SUM_INIT     = 16'hffff;
  localparam logic [7:0]  CHK_MARK     = 8'h80;
  localparam int          HDR_STORED   = 4;

  typedef enum logic [2:0] {
    STAT_CTRL_OK    = 3'd0,
    STAT_DATA_OK    = 3'd1,
    STAT_BAD_HEADER = 3'd2,
    STAT_BAD_SIZE   = 3'd3,
    STAT_CHECKSUM   = 3'd4,
    STAT_BAD_LENGTH = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_HEAD,
    ST_DATA,
    ST_CHECK,
    ST_DRAIN_RD,
    ST_DRAIN_WR
  } state_t;

  typedef enum logic [1:0] {
    OUT_HEADER,
    OUT_CHECK,
    OUT_PAYLOAD
  } out_kind_t;

  typedef struct packed {
    logic      hunt_start;
    logic      head_byte;
    logic      data_start;
    logic      data_byte;
    logic      drain_init;
    logic      drain_read;
    logic      drain_step;
    logic      out_load;
    out_kind_t out_kind;
  } cmd_t;

  typedef struct packed {
    logic is_start;
    logic hdr_last;
    logic hdr_to_data;
    logic data_last;
    logic chk_drain;
    logic drain_last;
    logic out_free;
  } stat_t;

endpackage

FILE: design/gpr_in_if.sv
interface gpr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;

  modport source (output valid, output line_byte, input ready);
  modport sink   (input valid, input line_byte, output ready);
endinterface

FILE: design/gpr_out_if.sv
interface gpr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [4:0] packet_type;
  logic [2:0] first_number;
  logic [2:0] second_number;
  logic [6:0] payload_length;
  logic [7:0] payload_byte;
  logic       payload_valid;
  logic       last_of_run;

  modport source (
    output valid, output status, output packet_type, output first_number,
    output second_number, output payload_length, output payload_byte,
    output payload_valid, output last_of_run, input ready
  );
  modport sink (
    input valid, input status, input packet_type, input first_number,
    input second_number, input payload_length, input payload_byte,
    input payload_valid, input last_of_run, output ready
  );
endinterface

FILE: design/gpr_ctrl.sv
module gpr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  gpr_pkg::stat_t stat,
  output gpr_pkg::cmd_t  cmd,
  output gpr_pkg::state_t state
);

  gpr_pkg::state_t state_r, state_nxt;
  logic accept;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gpr_pkg::ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Take line bytes only in the receive phases and when the result slot frees up
  always_comb begin
    in_ready = ((state_r == gpr_pkg::ST_HUNT) || (state_r == gpr_pkg::ST_HEAD) ||
                (state_r == gpr_pkg::ST_DATA)) && stat.out_free;
    accept   = in_valid && in_ready;
  end

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.out_kind   = gpr_pkg::OUT_HEADER;
    case (state_r)
      gpr_pkg::ST_HUNT: begin
        if (accept && stat.is_start) begin
          cmd.hunt_start = 1'b1;
          state_nxt      = gpr_pkg::ST_HEAD;
        end
      end
      gpr_pkg::ST_HEAD: begin
        if (accept) begin
          cmd.head_byte = 1'b1;
          if (stat.hdr_last) begin
            if (stat.hdr_to_data) begin
              cmd.data_start = 1'b1;
              state_nxt      = gpr_pkg::ST_DATA;
            end else begin
              cmd.out_load = 1'b1;
              cmd.out_kind = gpr_pkg::OUT_HEADER;
              state_nxt    = gpr_pkg::ST_HUNT;
            end
          end
        end
      end
      gpr_pkg::ST_DATA: begin
        if (accept) begin
          cmd.data_byte = 1'b1;
          if (stat.data_last) begin
            state_nxt = gpr_pkg::ST_CHECK;
          end
        end
      end
      gpr_pkg::ST_CHECK: begin
        if (stat.chk_drain) begin
          cmd.drain_init = 1'b1;
          state_nxt      = gpr_pkg::ST_DRAIN_RD;
        end else if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = gpr_pkg::OUT_CHECK;
          state_nxt    = gpr_pkg::ST_HUNT;
        end
      end
      gpr_pkg::ST_DRAIN_RD: begin
        cmd.drain_read = 1'b1;
        state_nxt      = gpr_pkg::ST_DRAIN_WR;
      end
      gpr_pkg::ST_DRAIN_WR: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_kind   = gpr_pkg::OUT_PAYLOAD;
          cmd.drain_step = 1'b1;
          state_nxt      = stat.drain_last ? gpr_pkg::ST_HUNT : gpr_pkg::ST_DRAIN_RD;
        end
      end
      default: begin
        state_nxt = gpr_pkg::ST_HUNT;
      end
    endcase
  end

  assign state = state_r;

endmodule

FILE: design/gpr_dp.sv
module gpr_dp #(
  parameter int DATA_BYTES = gpr_pkg::DATA_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     line_byte,
  input  gpr_pkg::cmd_t  cmd,
  output gpr_pkg::stat_t stat,
  input  logic           out_ready,
  output logic           out_valid,
  output logic [2:0]     out_status,
  output logic [4:0]     out_packet_type,
  output logic [2:0]     out_first_number,
  output logic [2:0]     out_second_number,
  output logic [6:0]     out_payload_length,
  output logic [7:0]     out_payload_byte,
  output logic           out_payload_valid,
  output logic           out_last_of_run
);

  localparam int ADDR_W = $clog2(DATA_BYTES);
  localparam int LEN_W  = $clog2(DATA_BYTES + 1);
  localparam int RES_W  = gpr_pkg::RES_W;

  // Receive state
  logic [ADDR_W-1:0] count_r;
  logic [7:0]        hdr_r [gpr_pkg::HDR_STORED];
  logic [7:0]        xor_r;
  logic [15:0]       sum_low_r, sum_low_nxt;
  logic [15:0]       sum_high_r, sum_high_nxt;
  logic [7:0]        pad_r;

  // Drain state
  logic [ADDR_W-1:0] addr_r;
  logic [RES_W-1:0]  rem_r;
  logic [6:0]        len7_r;
  logic [7:0]        rdata_r;
  logic [7:0]        mem [DATA_BYTES];

  // Result register
  logic              out_valid_r;
  logic [2:0]        status_r;
  logic [4:0]        type_r;
  logic [2:0]        first_r;
  logic [2:0]        second_r;
  logic [6:0]        length_r;
  logic [7:0]        byte_r;
  logic              pvalid_r;
  logic              last_r;

  logic [7:0]        h4;
  logic [6:0]        size_code;
  logic              hdr_bad;
  logic [15:0]       rot, csum, weight;
  logic [15:0]       got, want;
  logic              chk_ok, short_pkt, pad_bad;
  logic [LEN_W-1:0]  len;
  logic [RES_W-1:0]  n_res;
  logic              out_free;

  // Header decode for the fifth header byte
  always_comb begin
    h4        = hdr_r[3];
    size_code = hdr_r[0][6:0];
    hdr_bad   = (xor_r ^ line_byte) != 8'h00;
  end

  // Rotating checksum step for one data byte
  always_comb begin
    rot          = {sum_low_r[14:0], sum_low_r[15]};
    weight       = 16'(DATA_BYTES) - 16'(count_r);
    csum         = rot + {8'h00, line_byte};
    sum_high_nxt = sum_high_r + (csum ^ weight);
    sum_low_nxt  = (csum <= rot) ? (csum ^ sum_high_nxt) : csum;
  end

  // Packet verdict once all data bytes are in
  always_comb begin
    want      = {hdr_r[2], hdr_r[1]};
    got       = gpr_pkg::CHK_BASE - (sum_low_r ^ {8'h00, h4 | gpr_pkg::CHK_MARK});
    chk_ok    = got == want;
    short_pkt = h4[6];
    pad_bad   = short_pkt && ((pad_r == 8'h00) || (32'(pad_r) > 32'(DATA_BYTES)));
    len       = short_pkt ? (LEN_W'(DATA_BYTES) - LEN_W'(pad_r)) : LEN_W'(DATA_BYTES);
    n_res     = (32'(len) > 32'(gpr_pkg::MAX_RESULTS)) ? RES_W'(gpr_pkg::MAX_RESULTS)
                                                       : RES_W'(len);
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    stat             = '0;
    stat.is_start    = line_byte[6:0] == gpr_pkg::START_CODE;
    stat.hdr_last    = count_r == ADDR_W'(gpr_pkg::HDR_STORED);
    stat.hdr_to_data = !hdr_bad && (size_code == gpr_pkg::SIZE_DATA);
    stat.data_last   = count_r == ADDR_W'(DATA_BYTES - 1);
    stat.chk_drain   = chk_ok && !pad_bad && (len != '0);
    stat.drain_last  = rem_r == RES_W'(1);
    stat.out_free    = out_free;
  end

  // Advance the byte counter, header capture and checksum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      xor_r      <= '0;
      sum_low_r  <= gpr_pkg::SUM_INIT;
      sum_high_r <= '0;
      for (int i = 0; i < gpr_pkg::HDR_STORED; i++) begin
        hdr_r[i] <= '0;
      end
    end else begin
      if (cmd.hunt_start) begin
        count_r <= '0;
        xor_r   <= '0;
      end
      if (cmd.head_byte) begin
        xor_r <= xor_r ^ line_byte;
        if (count_r == ADDR_W'(gpr_pkg::HDR_STORED)) begin
          count_r <= '0;
        end else begin
          hdr_r[count_r[1:0]] <= line_byte;
          count_r             <= count_r + ADDR_W'(1);
        end
      end
      if (cmd.data_start) begin
        sum_low_r  <= gpr_pkg::SUM_INIT;
        sum_high_r <= '0;
      end
      if (cmd.data_byte) begin
        sum_low_r  <= sum_low_nxt;
        sum_high_r <= sum_high_nxt;
        count_r    <= stat.data_last ? '0 : count_r + ADDR_W'(1);
      end
    end
  end

  // Hold the pad count from the first data byte
  always_ff @(posedge clk) begin
    if (cmd.data_byte && (count_r == '0)) begin
      pad_r <= line_byte;
    end
  end

  // Packet buffer write
  always_ff @(posedge clk) begin
    if (cmd.data_byte) begin
      mem[count_r] <= line_byte;
    end
  end

  // Packet buffer read
  always_ff @(posedge clk) begin
    if (cmd.drain_read) begin
      rdata_r <= mem[addr_r];
    end
  end

  // Drain pointer and remaining result count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (cmd.drain_init) begin
      rem_r <= n_res;
    end else if (cmd.drain_step) begin
      rem_r <= rem_r - RES_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain_init) begin
      addr_r <= short_pkt ? ADDR_W'(1) : '0;
      len7_r <= 7'(len);
    end else if (cmd.drain_step) begin
      addr_r <= addr_r + ADDR_W'(1);
    end
  end

  // Result valid: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      type_r   <= '0;
      first_r  <= '0;
      second_r <= '0;
      length_r <= '0;
      byte_r   <= '0;
      pvalid_r <= 1'b0;
      last_r   <= 1'b1;
      case (cmd.out_kind)
        gpr_pkg::OUT_HEADER: begin
          if (hdr_bad) begin
            status_r <= gpr_pkg::STAT_BAD_HEADER;
          end else if (size_code == gpr_pkg::SIZE_CONTROL) begin
            status_r <= gpr_pkg::STAT_CTRL_OK;
            type_r   <= h4[7:3];
            first_r  <= h4[2:0];
          end else begin
            status_r <= gpr_pkg::STAT_BAD_SIZE;
          end
        end
        gpr_pkg::OUT_CHECK: begin
          if (!chk_ok) begin
            status_r <= gpr_pkg::STAT_CHECKSUM;
          end else if (pad_bad) begin
            status_r <= gpr_pkg::STAT_BAD_LENGTH;
          end else begin
            status_r <= gpr_pkg::STAT_DATA_OK;
            first_r  <= h4[2:0];
            second_r <= h4[5:3];
          end
        end
        gpr_pkg::OUT_PAYLOAD: begin
          status_r <= gpr_pkg::STAT_DATA_OK;
          first_r  <= h4[2:0];
          second_r <= h4[5:3];
          length_r <= len7_r;
          byte_r   <= rdata_r;
          pvalid_r <= 1'b1;
          last_r   <= rem_r == RES_W'(1);
        end
        default: begin
          status_r <= gpr_pkg::STAT_BAD_HEADER;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_packet_type    = type_r;
  assign out_first_number   = first_r;
  assign out_second_number  = second_r;
  assign out_payload_length = length_r;
  assign out_payload_byte   = byte_r;
  assign out_payload_valid  = pvalid_r;
  assign out_last_of_run    = last_r;

endmodule

FILE: design/g_protocol_packet_receiver_top.sv
// Channel   Dir  Item fields
// --------  ---  ---------------------------------------------------------------
// in_ch     in   line_byte
// out_ch    out  status, packet_type, first_number, second_number,
//                payload_length, payload_byte, payload_valid, last_of_run
//
// Line bytes are taken while hunting, in the header or in the data.
// After the last data byte a check state follows; a good data packet then drains
// from the packet buffer, each payload byte by a buffer read and then a result load.
// No line byte is taken during the check and the drain.
// A stalled result holds the input side until the result register frees up.
// Reset is synchronous; the packet buffer is not cleared.
module g_protocol_packet_receiver_top #(
  parameter int DATA_BYTES = gpr_pkg::DATA_BYTES_DEF
) (
  input logic      clk,
  input logic      rst_n,
  gpr_in_if.sink   in_ch,
  gpr_out_if.source out_ch
);

  gpr_pkg::cmd_t   cmd;
  gpr_pkg::stat_t  stat;
  gpr_pkg::state_t state;

  gpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd),
    .state    (state)
  );

  gpr_dp #(
    .DATA_BYTES (DATA_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .line_byte          (in_ch.line_byte),
    .cmd                (cmd),
    .stat               (stat),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_status         (out_ch.status),
    .out_packet_type    (out_ch.packet_type),
    .out_first_number   (out_ch.first_number),
    .out_second_number  (out_ch.second_number),
    .out_payload_length (out_ch.payload_length),
    .out_payload_byte   (out_ch.payload_byte),
    .out_payload_valid  (out_ch.payload_valid),
    .out_last_of_run    (out_ch.last_of_run)
  );

  // No line byte enters while a stalled result still occupies the result register
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> (!out_ch.valid || out_ch.ready))
    else $error("line byte taken while result register is blocked");

  // Payload bytes only come with a good data packet
  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.payload_valid) |-> (out_ch.status == gpr_pkg::STAT_DATA_OK))
    else $error("payload byte with a non-data status");

  // A result without payload closes its run
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.payload_valid) |-> out_ch.last_of_run)
    else $error("single result without last_of_run");

  // Input stays blocked through the buffer drain
  a_drain_block: assert property (@(posedge clk) disable iff (!rst_n)
    ((state == gpr_pkg::ST_DRAIN_RD) || (state == gpr_pkg::ST_DRAIN_WR)) |-> !in_ch.ready)
    else $error("line byte offered ready during drain");

endmodule
